// ===== rtl/drfb_pkg.sv =====
// shared types, frame constants and the object/subindex length table
// for the drive request frame builder; no dependencies
package drfb_pkg;

    localparam int IN_DATA_W   = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic       OP_WRITE    = 1'b1;
    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] ADDR_FLAG   = 8'h80;
    localparam logic [7:0] BLK_READ    = 8'h01;
    localparam logic [7:0] BLK_WRITE   = 8'h02;
    localparam logic [7:0] HDR_LEN     = 8'd6;

    // byte positions inside a frame
    localparam logic [3:0] POS_START  = 4'd0;
    localparam logic [3:0] POS_LEN    = 4'd1;
    localparam logic [3:0] POS_ADDR   = 4'd2;
    localparam logic [3:0] POS_BLK    = 4'd3;
    localparam logic [3:0] POS_OBJ_LO = 4'd4;
    localparam logic [3:0] POS_OBJ_HI = 4'd5;
    localparam logic [3:0] POS_SUB    = 4'd6;
    localparam logic [3:0] POS_DATA   = 4'd7;
    localparam logic [3:0] POS_MAX    = 4'd11;

    typedef struct packed {
        logic        err;
        logic        wr;
        logic [2:0]  dlen;
        logic [6:0]  addr;
        logic [15:0] obj;
        logic [7:0]  sub;
        logic [31:0] val;
        logic [7:0]  bcc;
        logic [3:0]  last_idx;
    } drfb_cmd_t;

    // data bytes of a write, zero when the object is not known
    function automatic logic [2:0] data_len(input logic [15:0] obj, input logic [7:0] sub);
        logic [2:0] len;
        len = 3'd0;
        if (sub == 8'd0 && obj >= 16'h2000 && obj <= 16'h231D) begin
            len = 3'd2;
        end
        else begin
            case (obj)
                16'h225F: len = (sub == 8'd1) ? 3'd2 : 3'd0;
                16'h2407: len = (sub == 8'd12) ? 3'd2 : 3'd0;
                16'h603F, 16'h6040, 16'h6041: len = (sub == 8'd0) ? 3'd2 : 3'd0;
                16'h6060, 16'h6061, 16'h6098: len = (sub == 8'd0) ? 3'd1 : 3'd0;
                16'h6064, 16'h607A, 16'h6081, 16'h6083, 16'h6084, 16'h609A:
                    len = (sub == 8'd0) ? 3'd4 : 3'd0;
                16'h6099: len = (sub == 8'd0) ? 3'd1 : 3'd4;
                16'h60FB:
                begin
                    if (sub == 8'd0)
                        len = 3'd1;
                    else if (sub == 8'd3)
                        len = 3'd4;
                    else
                        len = 3'd2;
                end
                default: len = 3'd0;
            endcase
        end
        return len;
    endfunction

endpackage

// ===== rtl/drfb_front.sv =====
// request front end: accepts a request, looks up the data length,
// precomputes the checksum and holds one command for the queue; uses drfb_pkg
module drfb_front
    import drfb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    output logic                 push,
    output drfb_cmd_t            push_cmd,
    input  logic                 q_full
);

    logic       front_valid_reg;
    logic       front_valid_next;
    drfb_cmd_t  cmd_reg;
    drfb_cmd_t  cmd_next;
    logic [2:0] len;
    logic [7:0] len_byte;
    logic [7:0] blk_byte;
    logic [7:0] data_x;
    logic       wr;
    logic       in_xfer;

    assign wr      = (s_tuser[0] == OP_WRITE);
    assign in_xfer = s_tvalid && s_tready;

    always_comb
    begin
        cmd_next.addr = s_tdata[6:0];
        cmd_next.obj  = s_tdata[22:7];
        cmd_next.sub  = s_tdata[30:23];
        cmd_next.val  = s_tdata[62:31];
        cmd_next.wr   = wr;
        len           = wr ? data_len(cmd_next.obj, cmd_next.sub) : 3'd0;
        cmd_next.dlen = len;
        cmd_next.err  = wr && (len == 3'd0);
        len_byte      = HDR_LEN + 8'(len);
        blk_byte      = wr ? BLK_WRITE : BLK_READ;
        // fold in only the data bytes that are actually sent
        data_x = 8'd0;
        if (len >= 3'd1)
            data_x = data_x ^ cmd_next.val[7:0];
        if (len >= 3'd2)
            data_x = data_x ^ cmd_next.val[15:8];
        if (len == 3'd4)
            data_x = data_x ^ cmd_next.val[23:16] ^ cmd_next.val[31:24];
        cmd_next.bcc = FRAME_START ^ len_byte ^ (ADDR_FLAG | {1'b0, cmd_next.addr})
                     ^ blk_byte ^ cmd_next.obj[7:0] ^ cmd_next.obj[15:8]
                     ^ cmd_next.sub ^ data_x;
        cmd_next.last_idx = cmd_next.err ? POS_START : (POS_DATA + 4'(len));
    end

    assign s_tready = !front_valid_reg || !q_full;
    assign push     = front_valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (in_xfer)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            cmd_reg <= cmd_next;
    end

endmodule

// ===== rtl/drfb_queue.sv =====
// short command queue between the front end and the byte serializer;
// uses drfb_pkg
module drfb_queue
    import drfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  drfb_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output drfb_cmd_t head_cmd
);

    drfb_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/drfb_back.sv =====
// byte serializer: walks the head command into an output register one frame byte
// per cycle while m_tready does not stall the output; uses drfb_pkg
module drfb_back
    import drfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  drfb_cmd_t head_cmd,
    output logic      pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_tdata,
    output logic      m_tlast,
    output logic [0:0] m_tuser
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_user_reg;
    logic       load;
    logic       is_last;
    logic [7:0] byte_val;
    logic [3:0] data_off;

    assign load     = head_valid && (!out_valid_reg || m_tready);
    assign is_last  = head_cmd.err || (idx_reg == head_cmd.last_idx);
    assign pop      = load && is_last;
    assign data_off = idx_reg - POS_DATA;

    always_comb
    begin
        if (head_cmd.err)
            byte_val = 8'd0;
        else if (idx_reg == head_cmd.last_idx)
            byte_val = head_cmd.bcc;
        else
        begin
            case (idx_reg)
                POS_START:  byte_val = FRAME_START;
                POS_LEN:    byte_val = HDR_LEN + 8'(head_cmd.dlen);
                POS_ADDR:   byte_val = ADDR_FLAG | {1'b0, head_cmd.addr};
                POS_BLK:    byte_val = head_cmd.wr ? BLK_WRITE : BLK_READ;
                POS_OBJ_LO: byte_val = head_cmd.obj[7:0];
                POS_OBJ_HI: byte_val = head_cmd.obj[15:8];
                POS_SUB:    byte_val = head_cmd.sub;
                default:    byte_val = head_cmd.val[data_off[1:0]*8 +: 8];
            endcase
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? POS_START : idx_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= POS_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= byte_val;
            out_last_reg <= is_last;
            out_user_reg <= head_cmd.err;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_user_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= POS_MAX)
        else $error("frame byte index past the longest frame");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
        else $error("error transaction not a single zero byte");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == POS_START))
        else $error("index not rewound after a command finished");

endmodule

// ===== rtl/drive_request_frame_builder.sv =====
// Drive request frame builder. A request enters on the s_ channel: s_tuser[0] is
// the operation (0 read, 1 write), s_tdata holds drive_addr, object_index, sub_index
// and write_value. The m_ channel returns the frame one byte per transaction in wire
// order, m_tlast marking the checksum byte. A write to an object that is not in the
// length table returns one transaction with m_tdata 0, m_tlast 1 and m_tuser[0] 1.
// The request passes through the front register, the queue and the output register
// before its first byte is valid. Throughput: one byte per cycle from the single-byte
// serializer while m_tready does not stall it; a frame is 8 to 12 bytes and an error
// result one byte. Requests are accepted back to back while up to two commands wait
// in the queue and one sits in the front register. A stall on m_tready holds the
// current byte and backs up the queue, after which s_tready drops. Reset empties the
// front register, the queue and the output register; no frame is in flight afterwards.
// Depends on drfb_pkg, drfb_front, drfb_queue and drfb_back.
module drive_request_frame_builder
    import drfb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // drive_addr[6:0], object_index[22:7], sub_index[30:23], write_value[62:31], zero[63]
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,   // op[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // frame_byte[7:0]
    output logic                 m_tlast,
    output logic [0:0]           m_tuser    // unknown_object[0]
);

    logic      push;
    drfb_cmd_t push_cmd;
    logic      q_full;
    logic      pop;
    logic      head_valid;
    drfb_cmd_t head_cmd;

    drfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    drfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    drfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
